FILE: rtl/core/indexed_list_store_top_defines.svh
// assertion macros used by the top module
`ifndef INDEXED_LIST_STORE_TOP_DEFINES_SVH
`define INDEXED_LIST_STORE_TOP_DEFINES_SVH

// same-cycle implication
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ils_pkg.sv
package ils_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   localparam logic [OP_W-1:0] OP_READ   = 3'd0;
   localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
   localparam logic [OP_W-1:0] OP_BACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_AT     = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic ins;
      logic del;
      logic rd;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/ils_req_if.sv
interface ils_req_if;
   logic                                valid;
   logic                                ready;
   logic [ils_pkg::OP_W-1:0]            operation;
   logic [ils_pkg::POS_W-1:0]           position;
   logic signed [ils_pkg::VAL_W-1:0]    value_in;

   modport source (output valid, operation, position, value_in, input ready);
   modport sink (input valid, operation, position, value_in, output ready);
endinterface

FILE: rtl/core/ils_rsp_if.sv
interface ils_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ils_pkg::VAL_W-1:0]    value_out;
   logic                                found;
   logic [ils_pkg::STATUS_W-1:0]        status;
   logic [ils_pkg::LEN_W-1:0]           length_now;

   modport source (output valid, value_out, found, status, length_now, input ready);
   modport sink (input valid, value_out, found, status, length_now, output ready);
endinterface

FILE: rtl/core/indexed_list_store_top.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of CAPACITY cells.
// Every insert or delete shifts all affected cells toward or away from their neighbor
// together, so one request is taken per clock while results are taken as fast;
// the cells update and latch the read entry at the request transfer edge, the
// request is held in the pending register, and the result register loads from both
// once the result side is free. While a result waits, one more request can be held,
// after which the request side stalls too. The read path is an OR across all cells.
// The list is empty after reset; no clearing pass is needed.
`include "indexed_list_store_top_defines.svh"

module indexed_list_store_top #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ils_req_if.sink     req_chan,
   ils_rsp_if.source   rsp_chan
);

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > ils_pkg::LEN_W) ? LW : ils_pkg::LEN_W;

   logic [CW-1:0] len_ff, len_in;

   logic                              pend_ff;
   logic                              pend_read_ff;
   logic                              pend_hit_ff;
   logic [ils_pkg::STATUS_W-1:0]      pend_status_ff;
   logic [ils_pkg::LEN_W-1:0]         pend_len_ff;

   logic                              rsp_valid_ff;
   logic signed [ils_pkg::VAL_W-1:0]  value_out_ff;
   logic                              found_ff;
   logic [ils_pkg::STATUS_W-1:0]      status_ff;
   logic [ils_pkg::LEN_W-1:0]         length_now_ff;

   logic                              accept, move;
   logic [CW-1:0]                     pos_ext, ins_pos, cell_pos;
   logic                              is_ins, full, do_ins, do_del, rd_hit;
   logic [ils_pkg::STATUS_W-1:0]      status_dec;
   ils_pkg::cell_ctrl_type            ctrl;

   logic signed [ils_pkg::VAL_W-1:0]  cell_data [CAPACITY];
   logic signed [ils_pkg::VAL_W-1:0]  cell_rd   [CAPACITY];
   logic signed [ils_pkg::VAL_W-1:0]  rd_or;

   assign move            = pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready  = !pend_ff || move;
   assign accept          = req_chan.valid && req_chan.ready;

   // request decode against the current length
   always_comb begin
      pos_ext    = CW'(req_chan.position);
      full       = (len_ff == CW'(CAPACITY));
      is_ins     = 1'b0;
      ins_pos    = pos_ext;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      rd_hit     = 1'b0;
      status_dec = ils_pkg::ST_DONE;
      unique case (req_chan.operation) inside
         ils_pkg::OP_READ: begin
            rd_hit = (pos_ext < len_ff);
            if (!rd_hit) begin
               status_dec = ils_pkg::ST_RANGE;
            end
         end
         ils_pkg::OP_FRONT, ils_pkg::OP_BACK, ils_pkg::OP_AT: begin
            is_ins = 1'b1;
            if (req_chan.operation == ils_pkg::OP_FRONT) begin
               ins_pos = '0;
            end else if (req_chan.operation == ils_pkg::OP_BACK) begin
               ins_pos = len_ff;
            end
            if (full) begin
               status_dec = ils_pkg::ST_FULL;
            end else if (ins_pos > len_ff) begin
               status_dec = ils_pkg::ST_RANGE;
            end else begin
               do_ins = 1'b1;
            end
         end
         ils_pkg::OP_DELETE: begin
            do_del = (pos_ext < len_ff);
            if (!do_del) begin
               status_dec = ils_pkg::ST_RANGE;
            end
         end
         default: begin
            status_dec = ils_pkg::ST_RANGE;
         end
      endcase
      cell_pos = is_ins ? ins_pos : pos_ext;
      ctrl.ins = accept && do_ins;
      ctrl.del = accept && do_del;
      ctrl.rd  = accept && rd_hit;
   end

   always_comb begin
      len_in = len_ff;
      if (ctrl.ins) begin
         len_in = len_ff + CW'(1);
      end else if (ctrl.del) begin
         len_in = len_ff - CW'(1);
      end
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ils_pkg::VAL_W-1:0] left_val, right_val;
      if (i == 0) begin : g_first
         assign left_val = req_chan.value_in;
      end else begin : g_left
         assign left_val = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_val = cell_data[i];
      end else begin : g_right
         assign right_val = cell_data[i+1];
      end
      ils_cell #(.CW(CW)) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .pos      (cell_pos),
         .idx      (CW'(i)),
         .ins_val  (req_chan.value_in),
         .left     (left_val),
         .right    (right_val),
         .data_out (cell_data[i]),
         .rd_out   (cell_rd[i])
      );
   end

   always_comb begin
      rd_or = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         rd_or = rd_or | cell_rd[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         if (accept) begin
            pend_ff <= 1'b1;
         end else if (move) begin
            pend_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         pend_read_ff   <= (req_chan.operation == ils_pkg::OP_READ);
         pend_hit_ff    <= rd_hit;
         pend_status_ff <= status_dec;
         pend_len_ff    <= len_in[ils_pkg::LEN_W-1:0];
      end
      if (move) begin
         if (pend_hit_ff) begin
            value_out_ff <= rd_or;
         end else if (pend_read_ff) begin
            value_out_ff <= ils_pkg::MISS_VALUE;
         end else begin
            value_out_ff <= '0;
         end
         found_ff      <= pend_hit_ff;
         status_ff     <= pend_status_ff;
         length_now_ff <= pend_len_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value_out  = value_out_ff;
   assign rsp_chan.found      = found_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.length_now = length_now_ff;

   `ILS_ASSERT_NOW(a_len_bound, 1'b1, len_ff <= CW'(CAPACITY), "length above capacity")
   `ILS_ASSERT_NOW(a_found_done, rsp_valid_ff && found_ff, status_ff == ils_pkg::ST_DONE, "bad found")
   `ILS_ASSERT_NEXT(a_full_hold, accept && is_ins && full, $stable(len_ff), "full insert moved length")
   `ILS_ASSERT_NOW(a_one_update, 1'b1, !(ctrl.ins && ctrl.del), "insert and delete together")

endmodule

FILE: rtl/core/ils_cell.sv
module ils_cell #(
   parameter int CW = 7
) (
   input  logic                               clock,
   input  ils_pkg::cell_ctrl_type             ctrl,
   input  logic [CW-1:0]                      pos,
   input  logic [CW-1:0]                      idx,
   input  logic signed [ils_pkg::VAL_W-1:0]   ins_val,
   input  logic signed [ils_pkg::VAL_W-1:0]   left,
   input  logic signed [ils_pkg::VAL_W-1:0]   right,
   output logic signed [ils_pkg::VAL_W-1:0]   data_out,
   output logic signed [ils_pkg::VAL_W-1:0]   rd_out
);

   logic signed [ils_pkg::VAL_W-1:0] data_ff, data_in;
   logic signed [ils_pkg::VAL_W-1:0] rd_ff, rd_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (idx > pos) begin
            data_in = left;
         end else if (idx == pos) begin
            data_in = ins_val;
         end
      end else if (ctrl.del && (idx >= pos)) begin
         data_in = right;
      end
   end

   always_comb begin
      rd_in = rd_ff;
      if (ctrl.rd) begin
         rd_in = (idx == pos) ? data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data_out = data_ff;
   assign rd_out   = rd_ff;

endmodule

FILE: tb/indexed_list_store_top_tb.sv
`timescale 1ns / 1ps

module indexed_list_store_top_tb;

   localparam int LIST_CAPACITY  = ils_pkg::CAPACITY_DEFAULT;
   localparam int REQUEST_TARGET = 600;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   // operation codes the block does not define
   localparam logic [ils_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
   localparam logic [ils_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [ils_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct {
      logic signed [ils_pkg::VAL_W-1:0] value;
      logic                             found;
      logic [ils_pkg::STATUS_W-1:0]     status;
      logic [ils_pkg::LEN_W-1:0]        length;
   } list_result_type;

   typedef struct {
      logic [ils_pkg::OP_W-1:0]         op;
      logic [ils_pkg::POS_W-1:0]        pos;
      logic signed [ils_pkg::VAL_W-1:0] val;
      bit                               pinned;
      list_result_type                  want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ils_req_if req_bus ();
   ils_rsp_if rsp_bus ();

   indexed_list_store_top #(
      .CAPACITY(LIST_CAPACITY)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always #1 clock = ~clock;

   logic signed [ils_pkg::VAL_W-1:0] list_shadow[$];
   list_result_type                  pending_results[$];
   directed_row_type                 directed_rows[$];

   int error_count    = 0;
   int sent_count     = 0;
   int applied_count  = 0;
   int read_hit_count = 0;
   int range_count    = 0;
   int full_count     = 0;
   int fill_count     = 0;
   int checked_count  = 0;

   bit grow_mode    = 1'b1;
   int full_visits  = 0;
   int full_target  = 4;
   int empty_visits = 0;

   int unsigned send_burst_left = 0;
   int unsigned rsp_burst_left  = 0;
   int unsigned rsp_stall_left  = 0;
   int unsigned idle_cycles;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic list_result_type apply_list_op(
         input logic [ils_pkg::OP_W-1:0] op,
         input logic [ils_pkg::POS_W-1:0] pos,
         input logic signed [ils_pkg::VAL_W-1:0] val);
      list_result_type res;
      int              slot;
      res.value  = '0;
      res.found  = 1'b0;
      res.status = ils_pkg::ST_DONE;
      case (op) inside
         ils_pkg::OP_READ: begin
            if (pos < list_shadow.size()) begin
               res.value = list_shadow[pos];
               res.found = 1'b1;
            end else begin
               res.value  = ils_pkg::MISS_VALUE;
               res.status = ils_pkg::ST_RANGE;
            end
         end
         ils_pkg::OP_FRONT, ils_pkg::OP_BACK, ils_pkg::OP_AT: begin
            slot = (op == ils_pkg::OP_FRONT) ? 0 :
                   (op == ils_pkg::OP_BACK) ? list_shadow.size() : int'(pos);
            if (list_shadow.size() >= LIST_CAPACITY) res.status = ils_pkg::ST_FULL;
            else if (slot > list_shadow.size()) res.status = ils_pkg::ST_RANGE;
            else list_shadow.insert(slot, val);
         end
         ils_pkg::OP_DELETE: begin
            if (pos < list_shadow.size()) list_shadow.delete(pos);
            else res.status = ils_pkg::ST_RANGE;
         end
         default: res.status = ils_pkg::ST_RANGE;
      endcase
      res.length = ils_pkg::LEN_W'(list_shadow.size());
      return res;
   endfunction

   task automatic add_row(input logic [ils_pkg::OP_W-1:0] op,
                          input logic [ils_pkg::POS_W-1:0] pos,
                          input logic signed [ils_pkg::VAL_W-1:0] val);
      directed_row_type row;
      row.op     = op;
      row.pos    = pos;
      row.val    = val;
      row.pinned = 1'b0;
      row.want   = '{value: '0, found: 1'b0, status: ils_pkg::ST_DONE, length: '0};
      directed_rows.push_back(row);
   endtask

   task automatic add_pinned(input logic [ils_pkg::OP_W-1:0] op,
                             input logic [ils_pkg::POS_W-1:0] pos,
                             input logic signed [ils_pkg::VAL_W-1:0] val,
                             input logic signed [ils_pkg::VAL_W-1:0] value, input logic found,
                             input logic [ils_pkg::STATUS_W-1:0] status,
                             input logic [ils_pkg::LEN_W-1:0] length);
      directed_row_type row;
      row.op     = op;
      row.pos    = pos;
      row.val    = val;
      row.pinned = 1'b1;
      row.want   = '{value: value, found: found, status: status, length: length};
      directed_rows.push_back(row);
   endtask

   task automatic send_request(input logic [ils_pkg::OP_W-1:0] op,
                               input logic [ils_pkg::POS_W-1:0] pos,
                               input logic signed [ils_pkg::VAL_W-1:0] val, input bit pinned,
                               input list_result_type want);
      list_result_type res;
      int unsigned     gap;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.position  <= pos;
      req_bus.value_in  <= val;
      do @(posedge clock); while (!req_bus.ready);
      res = apply_list_op(op, pos, val);
      pending_results.push_back(pinned ? want : res);
      sent_count++;
      if (res.status == ils_pkg::ST_DONE) applied_count++;
      if (res.found) read_hit_count++;
      if (res.status == ils_pkg::ST_RANGE) range_count++;
      if (res.status == ils_pkg::ST_FULL) full_count++;
      if (res.status == ils_pkg::ST_DONE && op != ils_pkg::OP_READ &&
          res.length == LIST_CAPACITY) fill_count++;
      // alternate between filling the list and draining it
      if (grow_mode) begin
         if (res.status == ils_pkg::ST_FULL) full_visits++;
         if (full_visits >= full_target) begin
            grow_mode    = 1'b0;
            empty_visits = 0;
         end
      end else begin
         if (res.length == 0) empty_visits++;
         if (empty_visits >= 2) begin
            grow_mode   = 1'b1;
            full_visits = 0;
            full_target = $urandom_range(3, 8);
         end
      end
      if (send_burst_left > 0) begin
         send_burst_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0) send_burst_left = $urandom_range(30, 80);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pick_request(output logic [ils_pkg::OP_W-1:0] op,
                               output logic [ils_pkg::POS_W-1:0] pos,
                               output logic signed [ils_pkg::VAL_W-1:0] val);
      int unsigned r;
      int unsigned len;
      int unsigned top;
      len = list_shadow.size();
      r   = $urandom_range(0, 99);
      if (grow_mode) begin
         if (r < 22) op = ils_pkg::OP_FRONT;
         else if (r < 44) op = ils_pkg::OP_BACK;
         else if (r < 70) op = ils_pkg::OP_AT;
         else if (r < 82) op = ils_pkg::OP_READ;
         else if (r < 94) op = ils_pkg::OP_DELETE;
         else op = ils_pkg::OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
      end else begin
         if (r < 55) op = ils_pkg::OP_DELETE;
         else if (r < 75) op = ils_pkg::OP_READ;
         else if (r < 81) op = ils_pkg::OP_FRONT;
         else if (r < 86) op = ils_pkg::OP_BACK;
         else if (r < 94) op = ils_pkg::OP_AT;
         else op = ils_pkg::OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
      end
      // mostly positions inside the list, sometimes anywhere
      top = (op == ils_pkg::OP_AT) ? len : ((len > 0) ? len - 1 : 0);
      if (top > 63) top = 63;
      if ($urandom_range(0, 99) < 75) pos = ils_pkg::POS_W'($urandom_range(0, top));
      else pos = ils_pkg::POS_W'($urandom_range(0, 63));
      r = $urandom_range(0, 99);
      if (r < 3) val = 32'h8000_0000;
      else if (r < 6) val = 32'h7fff_ffff;
      else if (r < 8) val = -32'sd1;
      else if (r < 10) val = '0;
      else val = $urandom;
   endtask

   // result side: random stalls and checking
   initial begin
      list_result_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with none pending: value=%0d status=%0d",
                                         rsp_bus.value_out, rsp_bus.status));
            end else begin
               want = pending_results.pop_front();
               checked_count++;
               if (rsp_bus.value_out !== want.value || rsp_bus.found !== want.found ||
                   rsp_bus.status !== want.status || rsp_bus.length_now !== want.length) begin
                  report_mismatch($sformatf(
                     "result %0d: got value=%0d found=%b status=%0d len=%0d, want %0d %b %0d %0d",
                     checked_count, rsp_bus.value_out, rsp_bus.found, rsp_bus.status,
                     rsp_bus.length_now, want.value, want.found, want.status, want.length));
               end
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_burst_left > 0) rsp_burst_left--;
            else if ($urandom_range(0, 59) == 0) rsp_burst_left = $urandom_range(40, 120);
            else if ($urandom_range(0, 99) < 30) rsp_stall_left = pick_gap();
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("** indexed_list_store_top: FAILED **");
      $finish;
   end

   initial begin
      logic [ils_pkg::OP_W-1:0]         op;
      logic [ils_pkg::POS_W-1:0]        pos;
      logic signed [ils_pkg::VAL_W-1:0] val;
      list_result_type                  none;
      none = '{value: '0, found: 1'b0, status: ils_pkg::ST_DONE, length: '0};
      req_bus.valid     <= 1'b0;
      req_bus.operation <= ils_pkg::OP_READ;
      req_bus.position  <= '0;
      req_bus.value_in  <= '0;

      // empty list, undefined codes, extreme values, out of range positions, then a short list
      add_pinned(ils_pkg::OP_READ, 6'd0, 32'd0, ils_pkg::MISS_VALUE, 1'b0,
                 ils_pkg::ST_RANGE, 7'd0);
      add_pinned(ils_pkg::OP_READ, 6'd63, 32'd0, ils_pkg::MISS_VALUE, 1'b0,
                 ils_pkg::ST_RANGE, 7'd0);
      add_pinned(ils_pkg::OP_DELETE, 6'd0, 32'd0, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd0);
      add_pinned(ils_pkg::OP_AT, 6'd1, 32'd5, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd0);
      add_pinned(OP_SPARE5, 6'd0, 32'd0, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd0);
      add_pinned(OP_SPARE6, 6'd63, -32'sd1, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd0);
      add_pinned(OP_SPARE7, 6'd42, 32'h8000_0000, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd0);
      add_pinned(ils_pkg::OP_BACK, 6'd9, 32'h7fff_ffff, 32'd0, 1'b0, ils_pkg::ST_DONE, 7'd1);
      add_pinned(ils_pkg::OP_FRONT, 6'd63, 32'h8000_0000, 32'd0, 1'b0, ils_pkg::ST_DONE, 7'd2);
      add_pinned(ils_pkg::OP_AT, 6'd2, -32'sd1, 32'd0, 1'b0, ils_pkg::ST_DONE, 7'd3);
      add_pinned(ils_pkg::OP_AT, 6'd1, 32'd0, 32'd0, 1'b0, ils_pkg::ST_DONE, 7'd4);
      add_pinned(ils_pkg::OP_READ, 6'd0, 32'd0, 32'h8000_0000, 1'b1, ils_pkg::ST_DONE, 7'd4);
      add_row(ils_pkg::OP_READ, 6'd1, 32'd0);
      add_row(ils_pkg::OP_READ, 6'd2, 32'd0);
      add_row(ils_pkg::OP_READ, 6'd3, 32'd0);
      add_pinned(ils_pkg::OP_READ, 6'd4, 32'd0, ils_pkg::MISS_VALUE, 1'b0,
                 ils_pkg::ST_RANGE, 7'd4);
      add_pinned(ils_pkg::OP_AT, 6'd5, 32'd7, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd4);
      add_pinned(ils_pkg::OP_AT, 6'd63, 32'd1, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd4);
      add_pinned(ils_pkg::OP_DELETE, 6'd4, 32'd0, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd4);
      add_pinned(ils_pkg::OP_DELETE, 6'd63, 32'd0, 32'd0, 1'b0, ils_pkg::ST_RANGE, 7'd4);
      add_row(ils_pkg::OP_DELETE, 6'd0, 32'd0);
      add_row(ils_pkg::OP_DELETE, 6'd2, 32'd0);
      add_row(ils_pkg::OP_FRONT, 6'd0, 32'h5555_aaaa);
      add_row(ils_pkg::OP_READ, 6'd1, 32'd0);
      add_row(ils_pkg::OP_DELETE, 6'd1, 32'd0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                      directed_rows[i].pinned, directed_rows[i].want);

      while (sent_count < REQUEST_TARGET) begin
         pick_request(op, pos, val);
         send_request(op, pos, val, 1'b0, none);
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      $display("covered %0d requests: %0d applied, %0d read hits, %0d out of range,",
               sent_count, applied_count, read_hit_count, range_count);
      $display("%0d refused full, list reached capacity %0d times; %0d checked, %0d mismatches",
               full_count, fill_count, checked_count, error_count);
      if (error_count == 0) begin
         $display("** indexed_list_store_top: PASSED **");
      end else begin
         $display("** indexed_list_store_top: FAILED **");
      end
      $finish;
   end

endmodule
